>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bmts_pkg.sv
package bmts_pkg;

  localparam int unsigned CNT_W    = 16;
  localparam int unsigned STRIDE_W = 32;
  localparam int unsigned TILE_W   = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_TILES      = 3'd0,
    CFG_INNER_TILES    = 3'd1,
    CFG_COL_TILES      = 3'd2,
    CFG_A_BATCH_STRIDE = 3'd3,
    CFG_B_BATCH_STRIDE = 3'd4,
    CFG_BATCH_COUNT    = 3'd5,
    CFG_BROADCAST_B    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]    row_tiles;
    logic [CNT_W-1:0]    inner_tiles;
    logic [CNT_W-1:0]    col_tiles;
    logic [STRIDE_W-1:0] a_batch_stride;
    logic [STRIDE_W-1:0] b_batch_stride;
    logic [CNT_W-1:0]    batch_count;
    logic                broadcast_b;
  } cfg_t;

  typedef struct packed {
    logic [TILE_W-1:0] a_tile;
    logic [TILE_W-1:0] b_tile;
    logic              pair_valid;
    logic              last_pair;
  } result_t;

endpackage

>>> sv/bmts_in_if.sv
interface bmts_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

>>> sv/bmts_out_if.sv
interface bmts_out_if;
  logic                            valid;
  logic                            ready;
  logic [bmts_pkg::TILE_W-1:0]     a_tile;
  logic [bmts_pkg::TILE_W-1:0]     b_tile;
  logic                            pair_valid;
  logic                            last_pair;

  modport source (output valid, output a_tile, output b_tile, output pair_valid,
                  output last_pair, input ready);
  modport sink   (input valid, input a_tile, input b_tile, input pair_valid,
                  input last_pair, output ready);
endinterface

>>> sv/bmts_cfg_if.sv
interface bmts_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bmts_pkg::CFG_IDX_W-1:0]    index;
  logic [bmts_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/bmts_cfg.sv
module bmts_cfg (
  input  logic              clk,
  input  logic              rst_n,
  bmts_cfg_if.sink          cfg_ch,
  output bmts_pkg::cfg_t    cfg
);

  bmts_pkg::cfg_t cfg_r;
  bmts_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (bmts_pkg::cfg_reg_t'(cfg_ch.index))
        bmts_pkg::CFG_ROW_TILES:
          cfg_nxt.row_tiles = cfg_ch.data[bmts_pkg::CNT_W-1:0];
        bmts_pkg::CFG_INNER_TILES:
          cfg_nxt.inner_tiles = cfg_ch.data[bmts_pkg::CNT_W-1:0];
        bmts_pkg::CFG_COL_TILES:
          cfg_nxt.col_tiles = cfg_ch.data[bmts_pkg::CNT_W-1:0];
        bmts_pkg::CFG_A_BATCH_STRIDE:
          cfg_nxt.a_batch_stride = cfg_ch.data[bmts_pkg::STRIDE_W-1:0];
        bmts_pkg::CFG_B_BATCH_STRIDE:
          cfg_nxt.b_batch_stride = cfg_ch.data[bmts_pkg::STRIDE_W-1:0];
        bmts_pkg::CFG_BATCH_COUNT:
          cfg_nxt.batch_count = cfg_ch.data[bmts_pkg::CNT_W-1:0];
        bmts_pkg::CFG_BROADCAST_B:
          cfg_nxt.broadcast_b = cfg_ch.data[0];
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_tiles      <= bmts_pkg::CNT_W'(1);
      cfg_r.inner_tiles    <= bmts_pkg::CNT_W'(1);
      cfg_r.col_tiles      <= bmts_pkg::CNT_W'(1);
      cfg_r.a_batch_stride <= bmts_pkg::STRIDE_W'(1);
      cfg_r.b_batch_stride <= bmts_pkg::STRIDE_W'(1);
      cfg_r.batch_count    <= bmts_pkg::CNT_W'(1);
      cfg_r.broadcast_b    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> sv/bmts_walk.sv
`include "assert_macros.svh"

module bmts_walk #(
  parameter int unsigned DIM_BITS        = 16,
  parameter int unsigned TILE_INDEX_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bmts_pkg::cfg_t      cfg,
  input  logic                step,
  input  logic                restart,
  output bmts_pkg::result_t   res
);

  localparam int unsigned DW = DIM_BITS;
  localparam int unsigned TW = TILE_INDEX_BITS;
  // compare width holds position + 1 and any count
  localparam int unsigned CW = (DW + 1 > bmts_pkg::CNT_W) ? DW + 1 : bmts_pkg::CNT_W;

  logic [DW-1:0] batch_pos_r, row_pos_r, col_pos_r, inner_pos_r;
  logic [DW-1:0] batch_pos_nxt, row_pos_nxt, col_pos_nxt, inner_pos_nxt;
  logic [TW-1:0] a_cursor_r, b_cursor_r, a_base_r, b_base_r;
  logic [TW-1:0] a_cursor_nxt, b_cursor_nxt, a_base_nxt, b_base_nxt;
  logic          finished_r, finished_nxt;

  logic [DW-1:0] batch_e, row_e, col_e, inner_e;
  logic [TW-1:0] a_e, b_e, a_base_e, b_base_e;
  logic          finished_e;
  logic          empty, active;
  logic          inner_wrap, col_wrap, row_wrap, batch_wrap;
  logic [TW-1:0] a_plus1, b_plus_col, inner_x;
  logic [TW-1:0] a_base_step, b_base_step;

  // restart clears the walk ahead of this transaction
  always_comb begin
    batch_e    = restart ? '0 : batch_pos_r;
    row_e      = restart ? '0 : row_pos_r;
    col_e      = restart ? '0 : col_pos_r;
    inner_e    = restart ? '0 : inner_pos_r;
    a_e        = restart ? '0 : a_cursor_r;
    b_e        = restart ? '0 : b_cursor_r;
    a_base_e   = restart ? '0 : a_base_r;
    b_base_e   = restart ? '0 : b_base_r;
    finished_e = restart ? 1'b0 : finished_r;
  end

  assign empty = (cfg.row_tiles == '0) || (cfg.inner_tiles == '0) ||
                 (cfg.col_tiles == '0) || (cfg.batch_count == '0);
  assign active = !empty && !finished_e;

  assign inner_wrap = (CW'(inner_e) + CW'(1)) >= CW'(cfg.inner_tiles);
  assign col_wrap   = (CW'(col_e)   + CW'(1)) >= CW'(cfg.col_tiles);
  assign row_wrap   = (CW'(row_e)   + CW'(1)) >= CW'(cfg.row_tiles);
  assign batch_wrap = (CW'(batch_e) + CW'(1)) >= CW'(cfg.batch_count);

  assign inner_x     = TW'(cfg.inner_tiles);
  assign a_plus1     = a_e + TW'(1);
  assign b_plus_col  = b_e + TW'(cfg.col_tiles);
  assign a_base_step = a_base_e + TW'(cfg.a_batch_stride);
  assign b_base_step = cfg.broadcast_b ? b_base_e : b_base_e + TW'(cfg.b_batch_stride);

  always_comb begin
    batch_pos_nxt = batch_e;
    row_pos_nxt   = row_e;
    col_pos_nxt   = col_e;
    inner_pos_nxt = inner_e;
    a_cursor_nxt  = a_e;
    b_cursor_nxt  = b_e;
    a_base_nxt    = a_base_e;
    b_base_nxt    = b_base_e;
    finished_nxt  = finished_e;
    if (active) begin
      priority if (!inner_wrap) begin
        inner_pos_nxt = inner_e + DW'(1);
        a_cursor_nxt  = a_plus1;
        b_cursor_nxt  = b_plus_col;
      end else if (!col_wrap) begin
        // step A back to the row start; B steps by col_tiles less the B batch stride, plus one
        inner_pos_nxt = '0;
        col_pos_nxt   = col_e + DW'(1);
        a_cursor_nxt  = a_plus1 - inner_x;
        b_cursor_nxt  = b_plus_col - TW'(cfg.b_batch_stride) + TW'(1);
      end else if (!row_wrap) begin
        inner_pos_nxt = '0;
        col_pos_nxt   = '0;
        row_pos_nxt   = row_e + DW'(1);
        a_cursor_nxt  = a_plus1;
        b_cursor_nxt  = b_base_e;
      end else begin
        inner_pos_nxt = '0;
        col_pos_nxt   = '0;
        row_pos_nxt   = '0;
        batch_pos_nxt = batch_wrap ? '0 : batch_e + DW'(1);
        a_base_nxt    = a_base_step;
        b_base_nxt    = b_base_step;
        a_cursor_nxt  = a_base_step;
        b_cursor_nxt  = b_base_step;
        finished_nxt  = batch_wrap;
      end
    end
  end

  always_comb begin
    res.pair_valid = active;
    res.last_pair  = active && inner_wrap && col_wrap && row_wrap && batch_wrap;
    res.a_tile     = active ? bmts_pkg::TILE_W'(a_e) : '0;
    res.b_tile     = active ? bmts_pkg::TILE_W'(b_e) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_pos_r <= '0;
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      inner_pos_r <= '0;
      a_cursor_r  <= '0;
      b_cursor_r  <= '0;
      a_base_r    <= '0;
      b_base_r    <= '0;
      finished_r  <= 1'b0;
    end else if (step) begin
      batch_pos_r <= batch_pos_nxt;
      row_pos_r   <= row_pos_nxt;
      col_pos_r   <= col_pos_nxt;
      inner_pos_r <= inner_pos_nxt;
      a_cursor_r  <= a_cursor_nxt;
      b_cursor_r  <= b_cursor_nxt;
      a_base_r    <= a_base_nxt;
      b_base_r    <= b_base_nxt;
      finished_r  <= finished_nxt;
    end
  end

  `ASSERT_IMPL(a_last_is_valid, res.last_pair, res.pair_valid, "last_pair without a pair")
  `ASSERT_NEXT(a_last_finishes, step && res.last_pair, finished_r && (batch_pos_r == '0),
               "walk not finished after last pair")
  `ASSERT_NEXT(a_idle_holds, step && !restart && !res.pair_valid,
               $stable(a_cursor_r) && $stable(b_cursor_r) && $stable(inner_pos_r),
               "walk moved on an empty transaction")

endmodule

>>> sv/bmts_out.sv
`include "assert_macros.svh"

module bmts_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  bmts_pkg::result_t   res,
  output logic                up_ready,
  bmts_out_if.source          out_ch
);

  logic               valid_r, valid_nxt;
  bmts_pkg::result_t  data_r;

  // take a new result whenever the held one is empty or leaving
  assign up_ready  = !valid_r || out_ch.ready;
  assign valid_nxt = load || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.a_tile     = data_r.a_tile;
  assign out_ch.b_tile     = data_r.b_tile;
  assign out_ch.pair_valid = data_r.pair_valid;
  assign out_ch.last_pair  = data_r.last_pair;

  `ASSERT_IMPL(a_load_has_room, load, up_ready, "result loaded over a held transaction")
  `ASSERT_NEXT(a_load_shows, load, valid_r, "loaded result not presented")
  `ASSERT_ALWAYS(a_empty_takes, valid_r || up_ready, "empty stage refuses input")

endmodule

>>> sv/batched_matmul_tile_index_sequencer.sv
// Channel   Role    Payload
// in_ch     sink    restart
// out_ch    source  a_tile, b_tile, pair_valid, last_pair
// cfg_ch    sink    index, data (always ready)
//
// One transaction in per cycle; its result sits in the output register the
// next cycle. The walk counters and cursors update in the accepting cycle.
// Reset loads the register defaults (counts and strides 1, no broadcast) and
// clears the walk. A held result with out_ch.ready low stalls in_ch.ready.
module batched_matmul_tile_index_sequencer #(
  parameter int unsigned DIM_BITS        = 16,
  parameter int unsigned TILE_INDEX_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  bmts_in_if.sink     in_ch,
  bmts_out_if.source  out_ch,
  bmts_cfg_if.sink    cfg_ch
);

  bmts_pkg::cfg_t     cfg;
  bmts_pkg::result_t  res;
  logic               up_ready;
  logic               step;

  assign in_ch.ready = up_ready;
  assign step        = in_ch.valid && up_ready;

  bmts_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  bmts_walk #(
    .DIM_BITS        (DIM_BITS),
    .TILE_INDEX_BITS (TILE_INDEX_BITS)
  ) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step    (step),
    .restart (in_ch.restart),
    .res     (res)
  );

  bmts_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step),
    .res      (res),
    .up_ready (up_ready),
    .out_ch   (out_ch)
  );

endmodule
